// File: hdl/lpps_pkg.sv
// Shared types, constants and calibration tables for the line-position PID steering core.
package lpps_pkg;

    // Field and datapath widths
    localparam int RawW     = 12;
    localparam int ScaleW   = 10;
    localparam int TotalW   = 12;
    localparam int PosW     = 13;
    localparam int IntegW   = 32;
    localparam int GainW    = 20;
    localparam int DutyW    = 8;
    localparam int LevelW   = 10;
    localparam int OutDutyW = 16;
    localparam int CfgIdxW  = 4;
    localparam int CfgDataW = 20;

    // Divider: dividend width, divisor width, quotient bits per cycle
    localparam int DivW       = 24;
    localparam int DenW       = 12;
    localparam int DivBits    = 2;
    localparam int DivSteps   = DivW / DivBits;
    localparam int DivCountW  = $clog2(DivSteps);

    // Multiply-accumulate unit
    localparam int MacAW   = 21;
    localparam int MacBW   = 17;
    localparam int MacProdW = MacAW + MacBW;
    localparam int AccW    = 56;
    localparam int MacShift = 16;

    // Algorithm constants
    localparam int NumSensors = 4;
    localparam int SensIdxW   = $clog2(NumSensors);
    localparam int ScaleMax   = 1000;
    localparam int LostPos    = 2500;

    // Register reset values
    localparam logic [GainW-1:0]  GainPReset    = GainW'(262);
    localparam logic [GainW-1:0]  GainIReset    = GainW'(0);
    localparam logic [GainW-1:0]  GainDReset    = GainW'(131);
    localparam logic [DutyW-1:0]  BaseReset     = DutyW'(72);
    localparam logic [DutyW-1:0]  FloorReset    = DutyW'(60);
    localparam logic [DutyW-1:0]  CeilReset     = DutyW'(80);
    localparam logic [LevelW-1:0] WhiteReset    = LevelW'(800);
    localparam logic [LevelW-1:0] PresenceReset = LevelW'(100);

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_GAIN_P     = 4'd0,
        CFG_GAIN_I     = 4'd1,
        CFG_GAIN_D     = 4'd2,
        CFG_BASE_DUTY  = 4'd3,
        CFG_DUTY_FLOOR = 4'd4,
        CFG_DUTY_CEIL  = 4'd5,
        CFG_WHITE      = 4'd6,
        CFG_PRESENCE   = 4'd7
    } cfg_reg_e;

    // Input transaction: four raw ADC readings
    typedef struct packed {
        logic [RawW-1:0] raw_far_left;
        logic [RawW-1:0] raw_near_left;
        logic [RawW-1:0] raw_near_right;
        logic [RawW-1:0] raw_far_right;
    } in_item_t;

    // Output transaction: position and motor duties
    typedef struct packed {
        logic signed [PosW-1:0] line_position;
        logic                   line_lost;
        logic [OutDutyW-1:0]    left_duty;
        logic [OutDutyW-1:0]    right_duty;
    } out_item_t;

    // Divider request and response
    typedef struct packed {
        logic            start;
        logic [DivW-1:0] dividend;
        logic [DenW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [DivW-1:0] quotient;
    } div_rsp_t;

    // Multiply-accumulate command
    typedef struct packed {
        logic                    valid;
        logic                    clear;
        logic                    shift;
        logic                    negate;
        logic signed [MacAW-1:0] a;
        logic signed [MacBW-1:0] b;
    } mac_op_t;

    // Lower calibration limit per channel
    function automatic logic [RawW-1:0] cal_low(input logic [SensIdxW-1:0] idx);
        logic [RawW-1:0] r;
        case (idx)
            2'd0:    r = RawW'(1801);
            2'd1:    r = RawW'(1800);
            2'd2:    r = RawW'(1797);
            default: r = RawW'(1797);
        endcase
        return r;
    endfunction

    // Calibration span (high minus low) per channel
    function automatic logic [DenW-1:0] cal_span(input logic [SensIdxW-1:0] idx);
        logic [DenW-1:0] r;
        case (idx)
            2'd0:    r = DenW'(4040 - 1801);
            2'd1:    r = DenW'(4046 - 1800);
            2'd2:    r = DenW'(4054 - 1797);
            default: r = DenW'(4047 - 1797);
        endcase
        return r;
    endfunction

    // Position weight per channel, left negative
    function automatic logic signed [MacAW-1:0] sensor_weight(
        input logic [SensIdxW-1:0] idx);
        logic signed [MacAW-1:0] r;
        case (idx)
            2'd0:    r = -MacAW'(3000);
            2'd1:    r = -MacAW'(1000);
            2'd2:    r = MacAW'(1000);
            default: r = MacAW'(3000);
        endcase
        return r;
    endfunction

endpackage

// File: hdl/lpps_div.sv
// Iterative restoring divider, two quotient bits per cycle.
module lpps_div
    import lpps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DivCountW-1:0] cnt_reg;
    logic [DenW-1:0]      rem_reg;
    logic [DenW-1:0]      rem_next;
    logic [DivW-1:0]      work_reg;
    logic [DivW-1:0]      work_next;
    logic [DenW-1:0]      den_reg;

    // Two restoring steps: shift in a dividend bit, subtract when it fits
    always_comb
    begin
        logic [DenW:0] trial;
        rem_next  = rem_reg;
        work_next = work_reg;
        for (int i = 0; i < DivBits; i++)
        begin
            trial     = {rem_next, work_next[DivW-1]};
            work_next = {work_next[DivW-2:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next     = DenW'(trial - {1'b0, den_reg});
                work_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial[DenW-1:0];
            end
        end
    end

    // Control: load on start, count down the steps, flag completion
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DivCountW'(DivSteps - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, dividend/quotient shifter, divisor
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            rem_reg  <= '0;
            work_reg <= req.dividend;
            den_reg  <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = work_reg;

endmodule

// File: hdl/lpps_mac.sv
// Shared signed multiplier with registered product and wide accumulator.
module lpps_mac
    import lpps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mac_op_t                op,
    output logic signed [AccW-1:0] acc
);

    logic signed [MacProdW-1:0] prod_reg;
    logic signed [MacProdW-1:0] prod_next;
    logic                       pend_reg;
    logic                       shift_reg;
    logic                       negate_reg;
    logic signed [AccW-1:0]     acc_reg;
    logic signed [AccW-1:0]     term;
    logic signed [AccW-1:0]     ext;

    // Stage one: multiply
    assign prod_next = MacProdW'(op.a) * MacProdW'(op.b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            prod_reg   <= prod_next;
            shift_reg  <= op.shift;
            negate_reg <= op.negate;
        end
    end

    // Stage two: align, negate if asked, accumulate
    always_comb
    begin
        ext  = AccW'(prod_reg);
        term = shift_reg ? (ext <<< MacShift) : ext;
        if (negate_reg)
        begin
            term = -term;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.clear)
        begin
            acc_reg <= '0;
        end
        else if (pend_reg)
        begin
            acc_reg <= acc_reg + term;
        end
    end

    assign acc = acc_reg;

endmodule

// File: hdl/line_position_pid_steering_core.sv
// Top level: configuration registers, sequencer and output register of the steering core.
//
// Takes one transaction of four raw 12-bit line-sensor readings and returns one result:
// the weighted line position (or +/-2500 with line_lost set when no sensor sees white),
// and the left and right motor duties in Q8.8 after a PID correction, clamped to the
// floor and ceiling. The position division is skipped when no reading passes the
// presence level. A new transaction is taken only once the result of the last one is
// loaded into the output register, in the cycle after that load. The time a transaction
// takes is set by the shared divider, which produces two quotient bits a cycle over 24
// bits and is used once per sensor for calibration scaling and once for the position
// mean; the PID terms go through one shared multiplier-accumulator. in_stall is high
// while a transaction is being worked on; a finished result sits in the output
// register, so the next transaction can be taken while it waits. The integral and
// previous position are cleared by reset; the user must write configuration through
// cfg_write/cfg_index/cfg_data only while the core is idle (the core does not enforce
// this), and writes to indexes beyond the last register are ignored.
module line_position_pid_steering_core
    import lpps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output out_item_t           out_data,
    input  logic                cfg_write,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    typedef enum logic [15:0] {
        S_IDLE       = 16'b0000_0000_0000_0001,
        S_SCALE      = 16'b0000_0000_0000_0010,
        S_SCALE_WAIT = 16'b0000_0000_0000_0100,
        S_WEIGH      = 16'b0000_0000_0000_1000,
        S_DRAIN      = 16'b0000_0000_0001_0000,
        S_POS_DIV    = 16'b0000_0000_0010_0000,
        S_POS_WAIT   = 16'b0000_0000_0100_0000,
        S_POS        = 16'b0000_0000_1000_0000,
        S_INTEG      = 16'b0000_0001_0000_0000,
        S_MUL_ILO    = 16'b0000_0010_0000_0000,
        S_MUL_IHI    = 16'b0000_0100_0000_0000,
        S_MUL_D      = 16'b0000_1000_0000_0000,
        S_DRAIN2     = 16'b0001_0000_0000_0000,
        S_DUTY_L     = 16'b0010_0000_0000_0000,
        S_DUTY_R     = 16'b0100_0000_0000_0000,
        S_DONE       = 16'b1000_0000_0000_0000
    } state_t;

    localparam int DutyCalcW = AccW + 1;

    // Configuration registers
    logic [GainW-1:0]  gain_p_reg;
    logic [GainW-1:0]  gain_i_reg;
    logic [GainW-1:0]  gain_d_reg;
    logic [DutyW-1:0]  base_reg;
    logic [DutyW-1:0]  floor_reg;
    logic [DutyW-1:0]  ceil_reg;
    logic [LevelW-1:0] white_reg;
    logic [LevelW-1:0] presence_reg;

    // Sequencer and working registers
    state_t                   state_reg;
    state_t                   state_next;
    logic [RawW-1:0]          raw_reg [NumSensors];
    logic [SensIdxW-1:0]      idx_reg;
    logic [ScaleW-1:0]        s_reg;
    logic [TotalW-1:0]        total_reg;
    logic                     lost_reg;
    logic                     wneg_reg;
    logic signed [PosW-1:0]   pos_reg;
    logic signed [PosW-1:0]   pos_next;
    logic signed [PosW-1:0]   prev_reg;
    logic signed [IntegW-1:0] integ_reg;
    logic signed [IntegW-1:0] integ_next;
    logic [OutDutyW-1:0]      left_reg;
    logic [OutDutyW-1:0]      right_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    // Shared units
    div_req_t               div_req;
    div_rsp_t               div_rsp;
    mac_op_t                mac_op;
    logic signed [AccW-1:0] mac_acc;

    // Datapath helpers
    logic                      in_accept;
    logic                      out_load;
    logic [RawW-1:0]           raw_cur;
    logic [RawW-1:0]           low_cur;
    logic [RawW-1:0]           diff_cur;
    logic [DivW-1:0]           scale_dividend;
    logic [DivW:0]             wsum_abs;
    logic [ScaleW-1:0]         s_clamped;
    logic signed [PosW-1:0]    quot_pos;
    logic signed [IntegW:0]    integ_sum;
    logic signed [DutyCalcW-1:0] base_ext;
    logic signed [DutyCalcW-1:0] acc_ext;

    lpps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    lpps_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .acc   (mac_acc)
    );

    // Clamp a Q16 duty to floor then ceiling, keep Q8.8
    function automatic logic [OutDutyW-1:0] duty_clamp(
        input logic signed [DutyCalcW-1:0] v,
        input logic [DutyW-1:0]            lo_duty,
        input logic [DutyW-1:0]            hi_duty);
        logic signed [DutyCalcW-1:0] lo;
        logic signed [DutyCalcW-1:0] hi;
        logic signed [DutyCalcW-1:0] r;
        lo = $signed({(DutyCalcW - DutyW - 16)'(0), lo_duty, 16'h0000});
        hi = $signed({(DutyCalcW - DutyW - 16)'(0), hi_duty, 16'h0000});
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r[OutDutyW+7:8];
    endfunction

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // Scaling operands for the current sensor
    assign raw_cur        = raw_reg[idx_reg];
    assign low_cur        = cal_low(idx_reg);
    assign diff_cur       = (raw_cur > low_cur) ? (raw_cur - low_cur) : '0;
    assign scale_dividend = DivW'(diff_cur) * DivW'(ScaleMax);
    assign s_clamped      = (div_rsp.quotient > DivW'(ScaleMax)) ? ScaleW'(ScaleMax)
                                                                 : div_rsp.quotient[ScaleW-1:0];

    // Magnitude of the weighted sum, which stays well inside 25 bits
    assign wsum_abs = mac_acc[AccW-1] ? -mac_acc[DivW:0] : mac_acc[DivW:0];

    // Signed quotient of the weighted mean, truncated toward zero
    assign quot_pos = wneg_reg ? -$signed(div_rsp.quotient[PosW-1:0])
                               : $signed(div_rsp.quotient[PosW-1:0]);

    // Final position: lost line overrides the mean
    always_comb
    begin
        if (lost_reg)
        begin
            pos_next = (prev_reg > 0) ? PosW'(LostPos) : -PosW'(LostPos);
        end
        else if (total_reg == '0)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = quot_pos;
        end
    end

    // Saturating integral update
    assign integ_sum = (IntegW + 1)'(integ_reg) + (IntegW + 1)'(pos_reg);
    always_comb
    begin
        if (integ_sum[IntegW] != integ_sum[IntegW-1])
        begin
            integ_next = integ_sum[IntegW] ? {1'b1, {(IntegW - 1){1'b0}}}
                                           : {1'b0, {(IntegW - 1){1'b1}}};
        end
        else
        begin
            integ_next = integ_sum[IntegW-1:0];
        end
    end

    assign base_ext = $signed({(DutyCalcW - DutyW - 16)'(0), base_reg, 16'h0000});
    assign acc_ext  = DutyCalcW'(mac_acc);

    // Next state and unit commands
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = scale_dividend;
        div_req.divisor  = cal_span(idx_reg);
        mac_op.valid     = 1'b0;
        mac_op.clear     = 1'b0;
        mac_op.shift     = 1'b0;
        mac_op.negate    = 1'b0;
        mac_op.a         = sensor_weight(idx_reg);
        mac_op.b         = $signed({(MacBW - ScaleW)'(0), s_reg});
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    mac_op.clear = 1'b1;
                    state_next   = S_SCALE;
                end
            end
            S_SCALE:
            begin
                div_req.start = 1'b1;
                state_next    = S_SCALE_WAIT;
            end
            S_SCALE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_WEIGH;
                end
            end
            S_WEIGH:
            begin
                mac_op.valid = (s_reg > presence_reg);
                state_next   = (idx_reg == SensIdxW'(NumSensors - 1)) ? S_DRAIN : S_SCALE;
            end
            S_DRAIN:
            begin
                state_next = S_POS_DIV;
            end
            S_POS_DIV:
            begin
                div_req.dividend = wsum_abs[DivW-1:0];
                div_req.divisor  = total_reg;
                if (total_reg == '0)
                begin
                    state_next = S_POS;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = S_POS_WAIT;
                end
            end
            S_POS_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_POS;
                end
            end
            S_POS:
            begin
                mac_op.clear = 1'b1;
                state_next   = S_INTEG;
            end
            S_INTEG:
            begin
                mac_op.valid = 1'b1;
                mac_op.a     = $signed({1'b0, gain_p_reg});
                mac_op.b     = MacBW'(pos_reg);
                state_next   = S_MUL_ILO;
            end
            S_MUL_ILO:
            begin
                mac_op.valid = 1'b1;
                mac_op.a     = $signed({1'b0, gain_i_reg});
                mac_op.b     = $signed({1'b0, integ_reg[15:0]});
                state_next   = S_MUL_IHI;
            end
            S_MUL_IHI:
            begin
                mac_op.valid = 1'b1;
                mac_op.shift = 1'b1;
                mac_op.a     = $signed({1'b0, gain_i_reg});
                mac_op.b     = MacBW'($signed(integ_reg[IntegW-1:16]));
                state_next   = S_MUL_D;
            end
            S_MUL_D:
            begin
                mac_op.valid  = 1'b1;
                mac_op.negate = 1'b1;
                mac_op.a      = $signed({1'b0, gain_d_reg});
                mac_op.b      = MacBW'(pos_reg) - MacBW'(prev_reg);
                state_next    = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_DUTY_L;
            end
            S_DUTY_L:
            begin
                state_next = S_DUTY_R;
            end
            S_DUTY_R:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, persistent loop state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            prev_reg      <= '0;
            integ_reg     <= '0;
            gain_p_reg    <= GainPReset;
            gain_i_reg    <= GainIReset;
            gain_d_reg    <= GainDReset;
            base_reg      <= BaseReset;
            floor_reg     <= FloorReset;
            ceil_reg      <= CeilReset;
            white_reg     <= WhiteReset;
            presence_reg  <= PresenceReset;
        end
        else
        begin
            state_reg <= state_next;

            // Hold the result until the receiver takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == S_INTEG)
            begin
                integ_reg <= integ_next;
            end
            if (state_reg == S_MUL_D)
            begin
                prev_reg <= pos_reg;
            end

            // Register writes; unknown indexes drop
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GAIN_P:     gain_p_reg   <= cfg_data[GainW-1:0];
                    CFG_GAIN_I:     gain_i_reg   <= cfg_data[GainW-1:0];
                    CFG_GAIN_D:     gain_d_reg   <= cfg_data[GainW-1:0];
                    CFG_BASE_DUTY:  base_reg     <= cfg_data[DutyW-1:0];
                    CFG_DUTY_FLOOR: floor_reg    <= cfg_data[DutyW-1:0];
                    CFG_DUTY_CEIL:  ceil_reg     <= cfg_data[DutyW-1:0];
                    CFG_WHITE:      white_reg    <= cfg_data[LevelW-1:0];
                    CFG_PRESENCE:   presence_reg <= cfg_data[LevelW-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // Per-transaction working registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    raw_reg[0] <= in_data.raw_far_left;
                    raw_reg[1] <= in_data.raw_near_left;
                    raw_reg[2] <= in_data.raw_near_right;
                    raw_reg[3] <= in_data.raw_far_right;
                    idx_reg    <= '0;
                    total_reg  <= '0;
                    lost_reg   <= 1'b1;
                end
            end
            S_SCALE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    s_reg <= s_clamped;
                end
            end
            S_WEIGH:
            begin
                if (s_reg > white_reg)
                begin
                    lost_reg <= 1'b0;
                end
                if (s_reg > presence_reg)
                begin
                    total_reg <= total_reg + TotalW'(s_reg);
                end
                idx_reg <= idx_reg + 1'b1;
            end
            S_POS_DIV:
            begin
                wneg_reg <= mac_acc[AccW-1];
            end
            S_POS:
            begin
                pos_reg <= pos_next;
            end
            S_DUTY_L:
            begin
                left_reg <= duty_clamp(base_ext + acc_ext, floor_reg, ceil_reg);
            end
            S_DUTY_R:
            begin
                right_reg <= duty_clamp(base_ext - acc_ext, floor_reg, ceil_reg);
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_data_reg.line_position <= pos_reg;
                    out_data_reg.line_lost     <= lost_reg;
                    out_data_reg.left_duty     <= left_reg;
                    out_data_reg.right_duty    <= right_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: verif/steering_checker.sv
// Checker for the steering core: predicts each result and compares it on arrival.
`timescale 1ns / 1ps

module steering_checker
    import lpps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  in_item_t            in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  out_item_t           out_data,
    input  logic                cfg_write,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  results_awaited,
    output int                  mismatch_total
);

    localparam int     MaxPrinted   = 100;
    localparam longint FullScale    = 1000;
    localparam longint LostPosition = 2500;
    localparam longint DutyOne      = 65536;
    localparam longint IntegMax     = 64'sd2147483647;
    localparam longint IntegMin     = -64'sd2147483648;

    // Shadow copy of the register file
    logic [GainW-1:0]  gain_p;
    logic [GainW-1:0]  gain_i;
    logic [GainW-1:0]  gain_d;
    logic [DutyW-1:0]  base_duty;
    logic [DutyW-1:0]  duty_floor;
    logic [DutyW-1:0]  duty_ceiling;
    logic [LevelW-1:0] white_lvl;
    logic [LevelW-1:0] presence_lvl;

    // Loop state carried from one transaction to the next
    int prev_position;
    int position_integral;

    out_item_t expected_steering[$];
    int        mismatches = 0;
    int        results_seen = 0;

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MaxPrinted)
            $display("[%0t] steering mismatch: %s", $time, what);
    endtask

    // Scale, locate the line, run the PID and clamp the duties
    task automatic predict_steering(input in_item_t item, output out_item_t res);
        logic [RawW-1:0] raws [NumSensors];
        longint cal_lo, cal_hi, weight, level, moment_sum, level_sum;
        longint pos, acc, corr, lo_limit, hi_limit, left, right;
        bit lost;
        int ch;
        raws[0] = item.raw_far_left;
        raws[1] = item.raw_near_left;
        raws[2] = item.raw_near_right;
        raws[3] = item.raw_far_right;
        moment_sum = 0;
        level_sum = 0;
        pos = 0;
        lost = 1'b1;
        for (ch = 0; ch < NumSensors; ch++)
        begin
            // calibration window and position weight of this channel
            case (ch)
                0:
                begin
                    cal_lo = 1801;
                    cal_hi = 4040;
                    weight = -3000;
                end
                1:
                begin
                    cal_lo = 1800;
                    cal_hi = 4046;
                    weight = -1000;
                end
                2:
                begin
                    cal_lo = 1797;
                    cal_hi = 4054;
                    weight = 1000;
                end
                default:
                begin
                    cal_lo = 1797;
                    cal_hi = 4047;
                    weight = 3000;
                end
            endcase
            // scale to 0..1000, truncating, then clamp the top
            if (longint'(raws[ch]) <= cal_lo)
                level = 0;
            else
                level = (longint'(raws[ch]) - cal_lo) * FullScale / (cal_hi - cal_lo);
            if (level > FullScale)
                level = FullScale;
            if (level > longint'(white_lvl))
                lost = 1'b0;
            if (level > longint'(presence_lvl))
            begin
                moment_sum += level * weight;
                level_sum += level;
            end
        end
        // weighted mean, truncated toward zero
        if (level_sum != 0)
            pos = moment_sum / level_sum;
        // line lost: hold the side it was last seen on
        if (lost)
            pos = (prev_position > 0) ? LostPosition : -LostPosition;

        // saturate the integral to 32 bits
        acc = longint'(position_integral) + pos;
        if (acc > IntegMax)
            acc = IntegMax;
        else if (acc < IntegMin)
            acc = IntegMin;
        corr = longint'(gain_p) * pos + longint'(gain_i) * acc
             - longint'(gain_d) * (pos - longint'(prev_position));
        position_integral = int'(acc);
        prev_position = int'(pos);

        // floor is tested before ceiling
        lo_limit = longint'(duty_floor) * DutyOne;
        hi_limit = longint'(duty_ceiling) * DutyOne;
        left = longint'(base_duty) * DutyOne + corr;
        right = longint'(base_duty) * DutyOne - corr;
        if (left < lo_limit)
            left = lo_limit;
        else if (left > hi_limit)
            left = hi_limit;
        if (right < lo_limit)
            right = lo_limit;
        else if (right > hi_limit)
            right = hi_limit;

        res.line_position = pos[PosW-1:0];
        res.line_lost = lost;
        res.left_duty = left[OutDutyW+7:8];
        res.right_duty = right[OutDutyW+7:8];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            gain_p = 20'd262;
            gain_i = 20'd0;
            gain_d = 20'd131;
            base_duty = 8'd72;
            duty_floor = 8'd60;
            duty_ceiling = 8'd80;
            white_lvl = 10'd800;
            presence_lvl = 10'd100;
            prev_position = 0;
            position_integral = 0;
            expected_steering.delete();
            results_awaited <= 0;
        end
        else
        begin
            // track register writes; unknown indexes are dropped
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_GAIN_P:     gain_p = cfg_data[GainW-1:0];
                    CFG_GAIN_I:     gain_i = cfg_data[GainW-1:0];
                    CFG_GAIN_D:     gain_d = cfg_data[GainW-1:0];
                    CFG_BASE_DUTY:  base_duty = cfg_data[DutyW-1:0];
                    CFG_DUTY_FLOOR: duty_floor = cfg_data[DutyW-1:0];
                    CFG_DUTY_CEIL:  duty_ceiling = cfg_data[DutyW-1:0];
                    CFG_WHITE:      white_lvl = cfg_data[LevelW-1:0];
                    CFG_PRESENCE:   presence_lvl = cfg_data[LevelW-1:0];
                    default:        ;
                endcase
            end

            // compare an accepted result against the oldest prediction
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (expected_steering.size() == 0)
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                else
                begin
                    want = expected_steering.pop_front();
                    if (got.line_position !== want.line_position)
                        report_mismatch($sformatf("result %0d line_position %0d, want %0d",
                            results_seen, got.line_position, want.line_position));
                    if (got.line_lost !== want.line_lost)
                        report_mismatch($sformatf("result %0d line_lost %0b, want %0b",
                            results_seen, got.line_lost, want.line_lost));
                    if (got.left_duty !== want.left_duty)
                        report_mismatch($sformatf("result %0d left_duty %0d, want %0d",
                            results_seen, got.left_duty, want.left_duty));
                    if (got.right_duty !== want.right_duty)
                        report_mismatch($sformatf("result %0d right_duty %0d, want %0d",
                            results_seen, got.right_duty, want.right_duty));
                end
                results_seen++;
            end

            // predict the result of an accepted sensor transaction
            if (in_valid && !in_stall)
            begin
                predict_steering(in_data, want);
                expected_steering.push_back(want);
            end
            results_awaited <= expected_steering.size();
        end
        mismatch_total <= mismatches;
    end

endmodule

// File: verif/tb.sv
// Testbench top for the steering core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb
    import lpps_pkg::*;
();

    localparam int WatchdogLimit = 5000;
    localparam int DrainCycles   = 120;
    localparam int HoldOffCycles = 500;
    localparam int PhaseItems    = 60;
    localparam int MaxGap        = 120;
    localparam int RawMax        = 2 ** RawW - 1;
    localparam int LineFloor     = 2600;
    localparam int DarkCeiling   = 1950;
    localparam int DimCeiling    = 2150;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    in_item_t            in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    out_item_t           out_data;
    logic                cfg_write = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    int results_awaited;
    int mismatch_total;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int idle_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    line_position_pid_steering_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    steering_checker steer_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_data        (out_data),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .results_awaited (results_awaited),
        .mismatch_total  (mismatch_total)
    );

    // Receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left = HoldOffCycles;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            idle_cycles <= 0;
        else if (idle_cycles == WatchdogLimit)
        begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $time, WatchdogLimit);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one sensor transaction, after an optional idle stretch
    task automatic send_item(input in_item_t item);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(MaxGap, 1);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    // Drain, reprogram every register, then run random transactions
    task automatic run_phase(input logic [GainW-1:0] gp, gi, gd,
                             input logic [DutyW-1:0] base, floor_duty, ceil_duty,
                             input logic [LevelW-1:0] white, presence,
                             input int idle_pct, stall_pct, input bit hold_off);
        logic [CfgDataW-1:0] junk;
        logic [RawW-1:0] raw [NumSensors];
        in_item_t item;
        int n, ch, kind, centre;
        bit wide, on_line;
        in_valid <= 1'b0;
        do @(posedge clk); while (results_awaited != 0);

        // upper bits above the duty and level registers' widths are junk and must be masked
        junk = CfgDataW'($urandom);
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_BASE_DUTY, {junk[CfgDataW-1:DutyW], base});
        write_reg(CFG_DUTY_FLOOR, {junk[CfgDataW-1:DutyW], floor_duty});
        write_reg(CFG_DUTY_CEIL, {junk[CfgDataW-1:DutyW], ceil_duty});
        write_reg(CFG_WHITE, {junk[CfgDataW-1:LevelW], white});
        write_reg(CFG_PRESENCE, {junk[CfgDataW-1:LevelW], presence});
        // an index past the last register must change nothing
        write_reg(CfgIdxW'($urandom_range(2 ** CfgIdxW - 1, int'(CFG_PRESENCE) + 1)), junk);
        cfg_write <= 1'b0;

        send_idle_pct = idle_pct;
        recv_stall_pct <= stall_pct;
        if (hold_off)
            hold_requests <= hold_requests + 1;

        for (n = 0; n < PhaseItems; n++)
        begin
            // mostly a line under one or two adjacent sensors, some dark, some noise
            kind = $urandom_range(99);
            centre = $urandom_range(NumSensors - 1);
            wide = 1'($urandom_range(1));
            for (ch = 0; ch < NumSensors; ch++)
            begin
                on_line = (ch == centre) || (wide && ch == centre + 1);
                if (kind < 55)
                    raw[ch] = on_line ? RawW'($urandom_range(RawMax, LineFloor))
                                      : RawW'($urandom_range(DarkCeiling));
                else if (kind < 70)
                    raw[ch] = RawW'($urandom_range(DimCeiling));
                else
                    raw[ch] = RawW'($urandom);
            end
            item.raw_far_left = raw[0];
            item.raw_near_left = raw[1];
            item.raw_near_right = raw[2];
            item.raw_far_right = raw[3];
            send_item(item);
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings; fields ordered far left to far right
        // lost straight after reset goes left
        send_item({12'd0, 12'd0, 12'd0, 12'd0});
        send_item({12'd4095, 12'd4095, 12'd4095, 12'd4095});
        send_item({12'd4040, 12'd0, 12'd0, 12'd0});
        send_item({12'd0, 12'd4046, 12'd0, 12'd0});
        send_item({12'd0, 12'd0, 12'd4054, 12'd0});
        send_item({12'd0, 12'd0, 12'd0, 12'd4047});
        // lost with the line last seen on the right
        send_item({12'd0, 12'd0, 12'd0, 12'd0});
        // exactly at and just above the lower calibration limits
        send_item({12'd1801, 12'd1800, 12'd1797, 12'd1797});
        send_item({12'd1802, 12'd1801, 12'd1798, 12'd1798});
        send_item({12'd4095, 12'd0, 12'd0, 12'd0});
        // lost with the line last seen on the left
        send_item({12'd0, 12'd0, 12'd0, 12'd0});
        // one reading at the presence level, one just above it
        send_item({12'd2025, 12'd2027, 12'd0, 12'd4095});
        // a reading at the white level, then just above it
        send_item({12'd3593, 12'd0, 12'd0, 12'd0});
        send_item({12'd3595, 12'd0, 12'd0, 12'd0});
        // negative quotient must truncate toward zero
        send_item({12'd4040, 12'd0, 12'd2900, 12'd0});
        send_item({12'd0, 12'd3000, 12'd3000, 12'd0});
        send_item({12'hAAA, 12'h555, 12'hAAA, 12'h555});
        send_item({12'h555, 12'hAAA, 12'h555, 12'hAAA});
        // full swing from right edge to left edge
        send_item({12'd0, 12'd0, 12'd0, 12'd4095});
        send_item({12'd4095, 12'd0, 12'd0, 12'd0});

        // Random phases across settings and idling patterns
        run_phase(20'd262, 20'd1, 20'd131, 8'd72, 8'd60, 8'd80, 10'd800, 10'd100,
                  0, 0, 1'b0);
        run_phase(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 8'd255, 8'd0, 8'd255, 10'd0, 10'd0,
                  50, 0, 1'b0);
        // floor above ceiling, white level never reached
        run_phase(20'd0, 20'd0, 20'd0, 8'd0, 8'd255, 8'd0, 10'd1000, 10'd1000,
                  0, 50, 1'b0);
        run_phase(GainW'($urandom), GainW'($urandom), GainW'($urandom),
                  DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                  LevelW'($urandom_range(1000)), LevelW'($urandom_range(1000)),
                  8, 8, 1'b0);
        // long receiver hold-off so the core backs up into its input
        run_phase(20'd655, 20'd0, 20'd0, 8'd128, 8'd0, 8'd255, 10'd500, 10'd50,
                  0, 0, 1'b1);
        run_phase(GainW'($urandom), GainW'($urandom_range(64)), GainW'($urandom),
                  DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                  LevelW'($urandom_range(1000)), LevelW'($urandom_range(1000)),
                  50, 0, 1'b0);
        run_phase(20'd3000, 20'd20, 20'd1500, 8'd70, 8'd75, 8'd65, 10'd900, 10'd300,
                  0, 50, 1'b0);
        // levels above full scale: every transaction reads as lost
        run_phase(GainW'($urandom), GainW'($urandom), GainW'($urandom),
                  DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                  10'h3FF, 10'h3FF, 8, 8, 1'b0);
        run_phase(GainW'($urandom), GainW'($urandom), GainW'($urandom),
                  DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                  LevelW'($urandom_range(1000)), LevelW'($urandom_range(1000)),
                  0, 0, 1'b0);

        // wait for every result, then watch a while for strays
        in_valid <= 1'b0;
        do @(posedge clk); while (results_awaited != 0);
        repeat (DrainCycles) @(posedge clk);
        if (mismatch_total == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: line_position_pid_steering_core.f
hdl/lpps_pkg.sv
hdl/lpps_div.sv
hdl/lpps_mac.sv
hdl/line_position_pid_steering_core.sv
verif/steering_checker.sv
verif/tb.sv
